// ----- hdl/tmcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants and types of the text-mode character writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	localparam int unsigned DEF_COLUMNS = 80;
	localparam int unsigned DEF_ROWS    = 25;

	localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_SPACE     = 8'd32;
	localparam logic [7:0] RESET_COLOR    = 8'd7;

	// Fixed port widths of the result item
	localparam int unsigned OUT_ADDR_W = 11;
	localparam int unsigned OUT_COL_W  = 7;
	localparam int unsigned OUT_ROW_W  = 5;

	typedef struct packed {
		logic                  written;
		logic [OUT_ADDR_W-1:0] addr;
		logic [15:0]           value;
		logic [OUT_COL_W-1:0]  col;
		logic [OUT_ROW_W-1:0]  row;
	} result_t;

endpackage

// ----- hdl/tmcw_cursor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_cursor
// Cursor state and the per-item cell write / cursor update.
// ----------------------------------------------------------------------------
module tmcw_cursor #(
	parameter int unsigned COLUMNS = tmcw_pkg::DEF_COLUMNS,
	parameter int unsigned ROWS    = tmcw_pkg::DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_code,
	input  logic [7:0]        text_color,
	output tmcw_pkg::result_t res
);
	import tmcw_pkg::*;

	localparam int unsigned COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned ADDR_W = $clog2(COLUMNS * ROWS);

	localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);

	logic [COL_W-1:0]  col_q, col_next, cell_col;
	logic [ROW_W-1:0]  row_q, row_next, cell_row, row_inc;
	logic [ADDR_W-1:0] cell_addr;
	logic [31:0]       addr_ext, col_ext, row_ext;
	logic              written;
	logic [7:0]        cell_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	assign row_inc = (row_q == LAST_ROW) ? '0 : row_q + 1'b1;

	always_comb begin
		col_next  = col_q;
		row_next  = row_q;
		cell_col  = col_q;
		cell_row  = row_q;
		written   = 1'b1;
		cell_char = char_code;
		case (char_code)
			CHAR_BACKSPACE: begin
				if (col_q == '0) begin
					col_next = LAST_COL;
					row_next = (row_q == '0) ? LAST_ROW : row_q - 1'b1;
				end else begin
					col_next = col_q - 1'b1;
				end
				// the blanked cell is the one the cursor lands on
				cell_col  = col_next;
				cell_row  = row_next;
				cell_char = CHAR_SPACE;
			end
			CHAR_NEWLINE: begin
				col_next = '0;
				row_next = row_inc;
				written  = 1'b0;
			end
			default: begin
				if (col_q == LAST_COL) begin
					col_next = '0;
					row_next = row_inc;
				end else begin
					col_next = col_q + 1'b1;
				end
			end
		endcase
	end

	assign cell_addr = ADDR_W'(cell_row) * ADDR_W'(COLUMNS) + ADDR_W'(cell_col);
	assign addr_ext  = 32'(cell_addr);
	assign col_ext   = 32'(col_next);
	assign row_ext   = 32'(row_next);

	assign res.written = written;
	assign res.addr    = written ? addr_ext[OUT_ADDR_W-1:0] : '0;
	assign res.value   = written ? {text_color, cell_char} : '0;
	assign res.col     = col_ext[OUT_COL_W-1:0];
	assign res.row     = row_ext[OUT_ROW_W-1:0];

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < COLUMNS)
		else $error("cursor column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < ROWS)
		else $error("cursor row out of range");

	a_newline_col: assert property (@(posedge clk) disable iff (!arst_n)
		step && char_code == CHAR_NEWLINE |=> col_q == '0)
		else $error("newline did not return to column 0");

endmodule

// ----- hdl/text_mode_character_writer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_character_writer_unit
// Turns a stream of character bytes into screen cell writes and cursor moves.
// ----------------------------------------------------------------------------
// Takes one character per item and returns one result item per character,
// at a sustained rate of one item per clock while out_ready is high; each
// item passes the input register, the single cursor update, then the result
// register. Each result tells screen memory which cell to write (address is
// row * COLUMNS + column, value is color in the high byte and character in
// the low byte) and reports the cursor after the item. Backspace steps back,
// wrapping to the last column of the previous row (from the top-left cell to
// the bottom-right), and blanks that cell with a space. Newline goes to
// column 0 of the next row and writes nothing (address and value read 0).
// Other bytes are written at the cursor, which then advances, wrapping over
// columns and rows; there is no scrolling. The screen memory itself sits
// outside and is expected to come up filled with 0x0720 (space, color 7).
// text_color is taken on cfg_data whenever cfg_valid is high; change it only
// while no items are in flight.
// ----------------------------------------------------------------------------
module text_mode_character_writer_unit #(
	parameter int unsigned COLUMNS = tmcw_pkg::DEF_COLUMNS,
	parameter int unsigned ROWS    = tmcw_pkg::DEF_ROWS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: text_color
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [7:0]                        cfg_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        char_code,
	// result items
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              cell_written,
	output logic [tmcw_pkg::OUT_ADDR_W-1:0]   cell_address,
	output logic [15:0]                       cell_value,
	output logic [tmcw_pkg::OUT_COL_W-1:0]    cursor_column,
	output logic [tmcw_pkg::OUT_ROW_W-1:0]    cursor_row
);
	import tmcw_pkg::*;

	logic [7:0] text_color_q;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res_comb;

	logic       advance;   // result register free or being emptied
	logic       step;      // item in s1 moves to s2 (cursor updates)
	logic       load;      // new item accepted into s1

	// Config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_valid) begin
			text_color_q <= cfg_data;
		end
	end

	// Pipeline control
	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			char_s1 <= char_code;
		end
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	// Cursor state and cell write for the item in s1
	tmcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.text_color(text_color_q),
		.res       (res_comb)
	);

	assign out_valid     = valid_s2;
	assign cell_written  = res_s2.written;
	assign cell_address  = res_s2.addr;
	assign cell_value    = res_s2.value;
	assign cursor_column = res_s2.col;
	assign cursor_row    = res_s2.row;

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.written |-> res_s2.addr == '0 && res_s2.value == '0)
		else $error("newline result carries cell data");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_s1)
		else $error("accepted item lost at input register");

	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("stepped item lost at result register");

endmodule

// ----- tb/sv/text_mode_character_writer_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_character_writer_unit_test
// Self-checking bench for the text-mode character writer.
// ----------------------------------------------------------------------------
// A short table of hand-picked characters walks the cursor through its wraps
// (backspace from the top-left cell, advance off the last cell, newline on
// the last row, backspace from column 0). After that, bursts of random
// characters run under several colors, 0x00 and 0xFF among them. A cursor
// model inside the bench predicts every result item not given in the table.
// The sender and the receiver both idle at random. The receiver also holds
// off twice for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module text_mode_character_writer_unit_test;
	import tmcw_pkg::*;

	localparam int unsigned COLS        = DEF_COLUMNS;
	localparam int unsigned ROWS_N      = DEF_ROWS;
	localparam int unsigned CELLS       = COLS * ROWS_N;
	localparam int unsigned PHASES      = 6;
	localparam int unsigned PHASE_ITEMS = 125;
	localparam int unsigned HOLD_CYCLES = 48;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned DIR_ROWS    = 21;

	// Content of one random burst
	typedef enum logic [1:0] {
		BURST_MIXED,
		BURST_BACKSPACES,
		BURST_NEWLINES,
		BURST_PRINTABLE
	} burst_kind_t;

	// One row of the directed table: when 'given' is set, 'res' is the expected
	// result as read off by hand; otherwise the cursor model decides.
	typedef struct packed {
		logic [7:0] ch;
		logic       given;
		result_t    res;
	} char_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_ready;
	logic        cell_written;
	logic [OUT_ADDR_W-1:0] cell_address;
	logic [15:0] cell_value;
	logic [OUT_COL_W-1:0]  cursor_column;
	logic [OUT_ROW_W-1:0]  cursor_row;

	// Hand-checked expectation travels with the item it belongs to
	logic        given_row;
	result_t     given_res;

	// Cursor model state
	int unsigned model_col;
	int unsigned model_row;
	logic [7:0]  model_color;
	logic [15:0] screen_copy [CELLS];

	result_t     pending_results [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;

	// Receiver state
	logic [31:0] rx_cycle;
	int unsigned rx_taken;
	int unsigned hold_left;

	// Reset color is 7, so a blanked cell reads 0x0720.
	char_row_t directed_rows [DIR_ROWS] = '{
		// backspace at top-left wraps to the bottom-right cell
		'{CHAR_BACKSPACE, 1'b1, '{1'b1, 11'd1999, 16'h0720, 7'd79, 5'd24}},
		// advance off the very last cell wraps to row 0
		'{8'h5A,          1'b1, '{1'b1, 11'd1999, 16'h075A, 7'd0, 5'd0}},
		'{CHAR_BACKSPACE, 1'b1, '{1'b1, 11'd1999, 16'h0720, 7'd79, 5'd24}},
		// newline on the last row wraps to row 0, writes nothing
		'{CHAR_NEWLINE,   1'b1, '{1'b0, 11'd0, 16'h0000, 7'd0, 5'd0}},
		'{8'h00,          1'b1, '{1'b1, 11'd0, 16'h0700, 7'd1, 5'd0}},
		'{8'hFF,          1'b1, '{1'b1, 11'd1, 16'h07FF, 7'd2, 5'd0}},
		'{CHAR_BACKSPACE, 1'b1, '{1'b1, 11'd1, 16'h0720, 7'd1, 5'd0}},
		'{CHAR_NEWLINE,   1'b1, '{1'b0, 11'd0, 16'h0000, 7'd0, 5'd1}},
		// backspace at column 0 goes to the end of the previous row
		'{CHAR_BACKSPACE, 1'b1, '{1'b1, 11'd79, 16'h0720, 7'd79, 5'd0}},
		// advance past the last column
		'{8'h41,          1'b1, '{1'b1, 11'd79, 16'h0741, 7'd0, 5'd1}},
		// neighbors of the control codes are plain characters
		'{8'h09,          1'b0, '0},
		'{8'h0B,          1'b0, '0},
		'{8'h07,          1'b0, '0},
		'{8'h80,          1'b0, '0},
		'{8'h7F,          1'b0, '0},
		'{CHAR_SPACE,     1'b0, '0},
		'{8'h55,          1'b0, '0},
		'{8'hAA,          1'b0, '0},
		'{CHAR_NEWLINE,   1'b0, '0},
		'{CHAR_BACKSPACE, 1'b0, '0},
		'{CHAR_BACKSPACE, 1'b0, '0}
	};

	text_mode_character_writer_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_code     (char_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cell_written  (cell_written),
		.cell_address  (cell_address),
		.cell_value    (cell_value),
		.cursor_column (cursor_column),
		.cursor_row    (cursor_row)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Cursor model: applies one character and returns the result item.
	// ------------------------------------------------------------------
	function automatic result_t advance_cursor(input logic [7:0] ch);
		result_t     res;
		int unsigned addr;
		res = '0;
		if (ch == CHAR_BACKSPACE) begin
			if (model_col == 0) begin
				model_col = COLS;
				model_row = (model_row == 0) ? ROWS_N - 1 : model_row - 1;
			end
			model_col--;
			addr = model_row * COLS + model_col;
			screen_copy[addr] = {model_color, CHAR_SPACE};
			res.written = 1'b1;
			res.addr    = addr[OUT_ADDR_W-1:0];
			res.value   = {model_color, CHAR_SPACE};
		end else if (ch == CHAR_NEWLINE) begin
			model_col = 0;
			model_row = (model_row + 1 >= ROWS_N) ? 0 : model_row + 1;
		end else begin
			addr = model_row * COLS + model_col;
			screen_copy[addr] = {model_color, ch};
			res.written = 1'b1;
			res.addr    = addr[OUT_ADDR_W-1:0];
			res.value   = {model_color, ch};
			model_col++;
			if (model_col >= COLS) begin
				model_col = 0;
				model_row = (model_row + 1 >= ROWS_N) ? 0 : model_row + 1;
			end
		end
		res.col = model_col[OUT_COL_W-1:0];
		res.row = model_row[OUT_ROW_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s at cycle %0d: got 0x%0h, want 0x%0h",
			what, cycle_count, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Monitor: one process sees config writes, accepted characters and
	// accepted results in a fixed order, so the pending queue never races.
	// ------------------------------------------------------------------
	initial begin
		model_col      = 0;
		model_row      = 0;
		model_color    = RESET_COLOR;
		mismatch_count = 0;
		foreach (screen_copy[i])
			screen_copy[i] = {RESET_COLOR, CHAR_SPACE};
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model_color = cfg_data;
			if (in_valid && in_ready) begin
				want = advance_cursor(char_code);
				// hand-typed rows override the model, which still moves on
				if (given_row)
					want = given_res;
				pending_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = '{cell_written, cell_address, cell_value, cursor_column, cursor_row};
				if (pending_results.size() == 0) begin
					report_mismatch("result item with nothing pending", got.addr, 0);
				end else begin
					want = pending_results.pop_front();
					if (got.written !== want.written)
						report_mismatch("cell_written", got.written, want.written);
					if (got.addr !== want.addr)
						report_mismatch("cell_address", got.addr, want.addr);
					if (got.value !== want.value)
						report_mismatch("cell_value", got.value, want.value);
					if (got.col !== want.col)
						report_mismatch("cursor_column", got.col, want.col);
					if (got.row !== want.row)
						report_mismatch("cursor_row", got.row, want.row);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: steps through four stall patterns picked by rx_cycle[7:6],
	// and after the 60th and 450th result it holds off long enough to back
	// the block up into its input while the sender keeps offering.
	// ------------------------------------------------------------------
	initial begin
		out_ready <= 1'b0;
		rx_cycle  = 0;
		rx_taken  = 0;
		hold_left = 0;
	end

	always @(posedge clk) begin
		rx_cycle++;
		if (out_valid && out_ready) begin
			rx_taken++;
			if (rx_taken == 60 || rx_taken == 450)
				hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_cycle[7:6])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= ($urandom_range(0, 3) != 0);
				2'd2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (rx_cycle[1:0] != 2'd0);
			endcase
		end
	end

	// Watchdog
	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender helpers
	// ------------------------------------------------------------------
	// Offer one character and hold it until accepted.
	task automatic send_char(input logic [7:0] ch, input logic given, input result_t res);
		in_valid  <= 1'b1;
		char_code <= ch;
		given_row <= given;
		given_res <= res;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic idle_input(input int unsigned cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending and wait until every pending result has come back.
	// The first edge lets the monitor log the last accepted item.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_color(input logic [7:0] color);
		cfg_valid <= 1'b1;
		cfg_data  <= color;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] random_char(input burst_kind_t kind);
		logic [7:0] ch;
		int unsigned pick;
		case (kind)
			BURST_BACKSPACES: ch = CHAR_BACKSPACE;
			BURST_NEWLINES:   ch = CHAR_NEWLINE;
			BURST_PRINTABLE: begin
				do
					ch = 8'($urandom_range(0, 255));
				while (ch == CHAR_BACKSPACE || ch == CHAR_NEWLINE);
			end
			default: begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					ch = CHAR_BACKSPACE;
				else if (pick < 24)
					ch = CHAR_NEWLINE;
				else
					ch = 8'($urandom_range(0, 255));
			end
		endcase
		return ch;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int unsigned i;
		int unsigned phase;
		int unsigned sent;
		int unsigned len;
		int unsigned gap;
		burst_kind_t kind;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= 8'h00;
		in_valid  <= 1'b0;
		char_code <= 8'h00;
		given_row <= 1'b0;
		given_res <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, under the reset color
		for (i = 0; i < DIR_ROWS; i++) begin
			send_char(directed_rows[i].ch, directed_rows[i].given, directed_rows[i].res);
			if ($urandom_range(0, 3) == 0)
				idle_input($urandom_range(1, 3));
		end

		// Random phases, each under its own color; extremes come first
		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			if (phase == 0)
				write_color(8'h00);
			else if (phase == 1)
				write_color(8'hFF);
			else
				write_color(8'($urandom_range(0, 255)));

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				kind = burst_kind_t'($urandom_range(0, 9) < 4 ?
					$urandom_range(1, 3) : 0);
				// long runs carry the cursor across whole rows, both ways
				len = (kind == BURST_MIXED) ? $urandom_range(1, 24) : $urandom_range(1, 100);
				for (i = 0; i < len && sent < PHASE_ITEMS; i++) begin
					send_char(random_char(kind), 1'b0, '0);
					sent++;
				end
				// odd phases run back to back with no sender gaps
				if (phase % 2 == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					if (gap != 0)
						idle_input(gap);
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/tmcw_pkg.sv
hdl/tmcw_cursor.sv
hdl/text_mode_character_writer_unit.sv
tb/sv/text_mode_character_writer_unit_test.sv
